>>> hdl/anc_pkg.sv
// Package for the autotile neighbor classifier: field widths, config register
// indexes, edge modes, tile categories, queue command type and the category decision.
// No dependencies.
package anc_pkg;

  localparam int COL_W      = 6;
  localparam int ROW_W      = 6;
  localparam int IDX_W      = 7;
  localparam int SIZE_W     = 7;
  localparam int MODE_W     = 2;
  localparam int CAT_W      = 5;
  localparam int NB_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int Q_DEPTH    = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE   = 2'd2;

  localparam logic [MODE_W-1:0] EDGE_ZERO = 2'd0;
  localparam logic [MODE_W-1:0] EDGE_ONE  = 2'd1;
  localparam logic [MODE_W-1:0] EDGE_WRAP = 2'd2;

  localparam logic KIND_LOAD     = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  localparam logic [CAT_W-1:0] CAT_EMPTY     = 5'd0;
  localparam logic [CAT_W-1:0] CAT_CENTER    = 5'd1;
  localparam logic [CAT_W-1:0] CAT_SINGLE    = 5'd2;
  localparam logic [CAT_W-1:0] CAT_HORIZ_L   = 5'd3;
  localparam logic [CAT_W-1:0] CAT_HORIZ_C   = 5'd4;
  localparam logic [CAT_W-1:0] CAT_HORIZ_R   = 5'd5;
  localparam logic [CAT_W-1:0] CAT_VERT_T    = 5'd6;
  localparam logic [CAT_W-1:0] CAT_VERT_C    = 5'd7;
  localparam logic [CAT_W-1:0] CAT_VERT_B    = 5'd8;
  localparam logic [CAT_W-1:0] CAT_TOP       = 5'd9;
  localparam logic [CAT_W-1:0] CAT_BOTTOM    = 5'd10;
  localparam logic [CAT_W-1:0] CAT_LEFT      = 5'd11;
  localparam logic [CAT_W-1:0] CAT_RIGHT     = 5'd12;
  localparam logic [CAT_W-1:0] CAT_CORNER_TL = 5'd13;
  localparam logic [CAT_W-1:0] CAT_CORNER_TR = 5'd14;
  localparam logic [CAT_W-1:0] CAT_CORNER_BL = 5'd15;
  localparam logic [CAT_W-1:0] CAT_CORNER_BR = 5'd16;
  localparam logic [CAT_W-1:0] CAT_INSIDE_TL = 5'd17;
  localparam logic [CAT_W-1:0] CAT_INSIDE_TR = 5'd18;
  localparam logic [CAT_W-1:0] CAT_INSIDE_BL = 5'd19;
  localparam logic [CAT_W-1:0] CAT_INSIDE_BR = 5'd20;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_CLASSIFY = 2'd1,
    CMD_EMPTY    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] rows;
    logic [MODE_W-1:0] mode;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] lcol;
    logic [IDX_W-1:0] rcol;
    logic [IDX_W-1:0] urow;
    logic [IDX_W-1:0] drow;
    logic             solid;
    logic             mask;
    logic [NB_W-1:0]  force_en;
    logic [NB_W-1:0]  force_val;
  } cmd_t;

  function automatic logic [CAT_W-1:0] decide(input logic [NB_W-1:0] nb);
    logic l, r, u, d, ul, ur, dl, dr;
    logic [CAT_W-1:0] cat;
    l  = nb[0];
    r  = nb[1];
    u  = nb[2];
    d  = nb[3];
    ul = nb[4];
    ur = nb[5];
    dl = nb[6];
    dr = nb[7];
    if (nb == 8'hFF) cat = CAT_CENTER;
    else if (!u && !d) begin
      if (l && r) cat = CAT_HORIZ_C;
      else if (!l && !r) cat = CAT_SINGLE;
      else cat = l ? CAT_HORIZ_R : CAT_HORIZ_L;
    end else if (!l && !r) begin
      if (u && d) cat = CAT_VERT_C;
      else cat = d ? CAT_VERT_T : CAT_VERT_B;
    end
    else if (u && d && l && !r) cat = CAT_RIGHT;
    else if (u && d && !l && r) cat = CAT_LEFT;
    else if (u && !l && r && !d) cat = CAT_CORNER_BL;
    else if (u && l && !r && !d) cat = CAT_CORNER_BR;
    else if (d && r && !l && !u) cat = CAT_CORNER_TL;
    else if (d && !r && l && !u) cat = CAT_CORNER_TR;
    else if (u && d && !dr && dl) cat = CAT_INSIDE_TL;
    else if (u && d && dr && !dl) cat = CAT_INSIDE_TR;
    else if (u && d && ul && !ur) cat = CAT_INSIDE_BL;
    else if (u && d && !ul && ur) cat = CAT_INSIDE_BR;
    else cat = d ? CAT_TOP : CAT_BOTTOM;
    return cat;
  endfunction

endpackage

>>> hdl/anc_in_if.sv
// Input channel of the autotile neighbor classifier: load and classify transactions.
// Depends on anc_pkg.
interface anc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [anc_pkg::COL_W-1:0] col;
  logic [anc_pkg::ROW_W-1:0] row;
  logic                     solid_bit;
  logic                     mask_bit;

  modport source(output valid, kind, col, row, solid_bit, mask_bit, input ready);
  modport sink(input valid, kind, col, row, solid_bit, mask_bit, output ready);
endinterface

>>> hdl/anc_out_if.sv
// Result channel of the autotile neighbor classifier: category and neighbor bits.
// Depends on anc_pkg.
interface anc_out_if;
  logic                     valid;
  logic                     ready;
  logic [anc_pkg::CAT_W-1:0] category;
  logic [anc_pkg::NB_W-1:0]  neighbor_bits;

  modport source(output valid, category, neighbor_bits, input ready);
  modport sink(input valid, category, neighbor_bits, output ready);
endinterface

>>> hdl/anc_cfg_if.sv
// Configuration write channel of the autotile neighbor classifier.
// Depends on anc_pkg.
interface anc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [anc_pkg::CFG_IDX_W-1:0]  index;
  logic [anc_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> hdl/anc_ram.sv
// Generic single-port-write, single-read RAM with per-bit write mask and registered read.
// No dependencies.
module anc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [WIDTH-1:0]                      wmask,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask[i]) mem[waddr][i] <= wdata[i];
      end
    end
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> hdl/anc_front.sv
// Front end: accepts input transactions, drops loads outside the store, and turns
// classifies into queue commands with neighbor addresses and edge overrides. Uses anc_pkg.
module anc_front #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  anc_in_if.sink         in_ch,
  input  anc_pkg::cfg_t  cfg,
  input  logic           push_ready,
  output logic           push_valid,
  output anc_pkg::cmd_t  push_data
);

  logic [anc_pkg::IDX_W-1:0] c, r, c_inc, r_inc;
  logic                      lout, rout, uout, dout, keep;
  logic [anc_pkg::NB_W-1:0]  outside;

  always_comb begin
    c     = anc_pkg::IDX_W'(in_ch.col);
    r     = anc_pkg::IDX_W'(in_ch.row);
    c_inc = c + 7'd1;
    r_inc = r + 7'd1;
    lout  = (c == '0);
    rout  = (c_inc >= cfg.cols);
    dout  = (r == '0);
    uout  = (r_inc >= cfg.rows);
    outside = {rout | dout, lout | dout, rout | uout, lout | uout, dout, uout, rout, lout};

    push_data           = '0;
    push_data.col       = c;
    push_data.row       = r;
    push_data.lcol      = lout ? cfg.cols - 7'd1 : c - 7'd1;
    push_data.rcol      = rout ? '0 : c_inc;
    push_data.drow      = dout ? cfg.rows - 7'd1 : r - 7'd1;
    push_data.urow      = uout ? '0 : r_inc;
    push_data.solid     = in_ch.solid_bit;
    push_data.mask      = in_ch.mask_bit;
    push_data.force_en  = (cfg.mode == anc_pkg::EDGE_WRAP) ? '0 : outside;
    push_data.force_val = {anc_pkg::NB_W{cfg.mode == anc_pkg::EDGE_ONE}};

    keep = 1'b1;
    if (in_ch.kind == anc_pkg::KIND_LOAD) begin
      push_data.kind = anc_pkg::CMD_LOAD;
      keep = (int'(in_ch.col) < MAX_COLS) && (int'(in_ch.row) < MAX_ROWS);
    end else if ((c < cfg.cols) && (r < cfg.rows)) begin
      push_data.kind = anc_pkg::CMD_CLASSIFY;
    end else begin
      push_data.kind = anc_pkg::CMD_EMPTY;
    end
  end

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid && keep;

endmodule

>>> hdl/anc_fifo.sv
// Short command queue between front end and back end.
// Uses anc_pkg for the command type and depth.
module anc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  anc_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output anc_pkg::cmd_t head
);

  localparam int PW = $clog2(anc_pkg::Q_DEPTH);
  localparam int CW = $clog2(anc_pkg::Q_DEPTH + 1);

  anc_pkg::cmd_t  mem_r [anc_pkg::Q_DEPTH];
  logic [PW-1:0]  wptr_r, rptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full       = (cnt_r == CW'(anc_pkg::Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop) rptr_r <= rptr_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_data;
  end

endmodule

>>> hdl/anc_back.sv
// Back end: executes queued commands against the column-word map store and
// builds the classify result in the output register. Uses anc_pkg and anc_ram.
module anc_back #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  anc_pkg::cmd_t             head,
  output logic                      pop,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [anc_pkg::CAT_W-1:0] out_category,
  output logic [anc_pkg::NB_W-1:0]  out_neighbor_bits
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int WW = 2 * MAX_ROWS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CEN   = 5'b00010,
    ST_LEFT  = 5'b00100,
    ST_RIGHT = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  anc_pkg::cmd_t             cmd_r, cmd_nxt;
  logic                      solid_r, solid_nxt;
  logic                      u_r, u_nxt, d_r, d_nxt;
  logic                      l_r, l_nxt, ul_r, ul_nxt, dl_r, dl_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [anc_pkg::CAT_W-1:0] out_cat_r, out_cat_nxt;
  logic [anc_pkg::NB_W-1:0]  out_nb_r, out_nb_nxt;

  logic                      we, re, out_free;
  logic [AW-1:0]             waddr, raddr;
  logic [WW-1:0]             wdata, wmask, rdata;
  logic [MAX_ROWS-1:0]       occ_word, sol_word;
  logic [RW-1:0]             ri_c, ri_u, ri_d, ri_load;
  logic [anc_pkg::NB_W-1:0]  raw_nb, nb;

  anc_ram #(.WIDTH(WW), .DEPTH(MAX_COLS)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .wmask (wmask),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign occ_word = rdata[MAX_ROWS-1:0];
  assign sol_word = rdata[WW-1:MAX_ROWS];
  assign ri_c     = RW'(cmd_r.row);
  assign ri_u     = RW'(cmd_r.urow);
  assign ri_d     = RW'(cmd_r.drow);
  assign ri_load  = RW'(head.row);
  assign out_free = !out_valid_r || out_ready;

  assign waddr = AW'(head.col);
  assign wdata = {{MAX_ROWS{head.solid}}, {MAX_ROWS{head.solid | head.mask}}};
  assign wmask = (WW'(1) << ri_load) | (WW'(1) << (MAX_ROWS + int'(ri_load)));

  // bit order: L, R, U, D, UL, UR, DL, DR from bit 0
  assign raw_nb = {occ_word[ri_d], dl_r, occ_word[ri_u], ul_r, d_r, u_r, occ_word[ri_c], l_r};
  assign nb     = (raw_nb & ~cmd_r.force_en) | (cmd_r.force_val & cmd_r.force_en);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    solid_nxt     = solid_r;
    u_nxt         = u_r;
    d_nxt         = d_r;
    l_nxt         = l_r;
    ul_nxt        = ul_r;
    dl_nxt        = dl_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cat_nxt   = out_cat_r;
    out_nb_nxt    = out_nb_r;
    pop           = 1'b0;
    we            = 1'b0;
    re            = 1'b0;
    raddr         = AW'(head.col);

    case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          case (head.kind)
            anc_pkg::CMD_LOAD: begin
              pop = 1'b1;
              we  = 1'b1;
            end
            anc_pkg::CMD_CLASSIFY: begin
              pop       = 1'b1;
              re        = 1'b1;
              cmd_nxt   = head;
              state_nxt = ST_CEN;
            end
            default: begin
              if (out_free) begin
                pop           = 1'b1;
                out_valid_nxt = 1'b1;
                out_cat_nxt   = anc_pkg::CAT_EMPTY;
                out_nb_nxt    = '0;
              end
            end
          endcase
        end
      end
      ST_CEN: begin
        solid_nxt = sol_word[ri_c];
        u_nxt     = occ_word[ri_u];
        d_nxt     = occ_word[ri_d];
        re        = 1'b1;
        raddr     = AW'(cmd_r.lcol);
        state_nxt = ST_LEFT;
      end
      ST_LEFT: begin
        l_nxt     = occ_word[ri_c];
        ul_nxt    = occ_word[ri_u];
        dl_nxt    = occ_word[ri_d];
        re        = 1'b1;
        raddr     = AW'(cmd_r.rcol);
        state_nxt = ST_RIGHT;
      end
      ST_RIGHT, ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cat_nxt   = solid_r ? anc_pkg::decide(nb) : anc_pkg::CAT_EMPTY;
          out_nb_nxt    = solid_r ? nb : '0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    solid_r   <= solid_nxt;
    u_r       <= u_nxt;
    d_r       <= d_nxt;
    l_r       <= l_nxt;
    ul_r      <= ul_nxt;
    dl_r      <= dl_nxt;
    out_cat_r <= out_cat_nxt;
    out_nb_r  <= out_nb_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_category      = out_cat_r;
  assign out_neighbor_bits = out_nb_r;

endmodule

>>> hdl/autotile_neighbor_classifier.sv
// Autotile neighbor classifier: config registers, front end, command queue, back end.
// Loads: one per cycle while the back end is not busy with a classify; each is queued, then
// written to the map store from the queue head. Classify: the back end reads three column
// words (centre, left, right) through the single read port of the map store, then registers
// the result; it takes no new command until that result is registered, and holds while the output stalls.
// Reset clears config to 64 columns, 64 rows, edge mode zero; map contents are kept.
// Depends on anc_pkg, anc_*_if, anc_front, anc_fifo, anc_back, anc_ram.
module autotile_neighbor_classifier #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  anc_in_if.sink    in_ch,
  anc_out_if.source out_ch,
  anc_cfg_if.sink   cfg_ch
);

  localparam int ColCap = (MAX_COLS > 127) ? 127 : MAX_COLS;
  localparam int RowCap = (MAX_ROWS > 127) ? 127 : MAX_ROWS;

  logic [anc_pkg::SIZE_W-1:0] map_columns_r, map_rows_r;
  logic [anc_pkg::MODE_W-1:0] edge_mode_r;
  anc_pkg::cfg_t              cfg;
  logic                       push_valid, push_ready, q_full, q_valid, pop;
  anc_pkg::cmd_t              push_data, q_head;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_columns_r <= anc_pkg::SIZE_RESET;
      map_rows_r    <= anc_pkg::SIZE_RESET;
      edge_mode_r   <= anc_pkg::EDGE_ZERO;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        anc_pkg::REG_MAP_COLUMNS: map_columns_r <= cfg_ch.data;
        anc_pkg::REG_MAP_ROWS:    map_rows_r    <= cfg_ch.data;
        anc_pkg::REG_EDGE_MODE:   edge_mode_r   <= cfg_ch.data[anc_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (map_columns_r == '0) cfg.cols = 7'd1;
    else if (int'(map_columns_r) > ColCap) cfg.cols = anc_pkg::SIZE_W'(ColCap);
    else cfg.cols = map_columns_r;
    if (map_rows_r == '0) cfg.rows = 7'd1;
    else if (int'(map_rows_r) > RowCap) cfg.rows = anc_pkg::SIZE_W'(RowCap);
    else cfg.rows = map_rows_r;
    cfg.mode = edge_mode_r;
  end

  assign push_ready = !q_full;

  anc_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .in_ch      (in_ch),
    .cfg        (cfg),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  anc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  anc_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_valid),
    .head              (q_head),
    .pop               (pop),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_category      (out_ch.category),
    .out_neighbor_bits (out_ch.neighbor_bits)
  );

endmodule

>>> tb/testbench.sv
// Testbench for autotile_neighbor_classifier: fills the low and top-edge cells, then drives
// loads and classifies under random idling and backpressure, checked by an in-bench predictor.
// Depends on anc_pkg, anc_in_if, anc_out_if, anc_cfg_if and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_DIM = 64;
  localparam int RUN_LIMIT = 1_000_000;
  localparam int DRAIN_LIMIT = 20_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS = 45;
  localparam int FILL_SPAN = 12;
  localparam int FILL_COUNT = FILL_SPAN + 2;
  localparam logic [anc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [anc_pkg::MODE_W-1:0] EDGE_SPARE = 2'd3;

  typedef logic [anc_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct packed {
    logic [anc_pkg::CAT_W-1:0] category;
    logic [anc_pkg::NB_W-1:0]  nbits;
  } tile_result_t;

  logic clk;
  logic rst_n;

  anc_in_if  in_ch();
  anc_out_if out_ch();
  anc_cfg_if cfg_ch();

  autotile_neighbor_classifier #(
    .MAX_COLS(MAP_DIM),
    .MAX_ROWS(MAP_DIM)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  bit solid_map [MAP_DIM][MAP_DIM];
  bit mask_map [MAP_DIM][MAP_DIM];
  bit written_map [MAP_DIM][MAP_DIM];
  anc_pkg::cfg_t map_cfg;

  tile_result_t pending_tiles[$];
  tile_result_t want_tile;
  int mismatch_count = 0;
  int cycle_count = 0;
  bit sender_burst = 1'b0;
  int hold_request = 0;
  int hold_left = 0;
  int rx_stall_left = 0;
  int rx_phase_left = 0;
  bit rx_smooth = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic int used_extent(logic [anc_pkg::SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAP_DIM) return MAP_DIM;
    return int'(v);
  endfunction

  // low indexes, then the two top indexes
  function automatic int fill_coord(int k);
    if (k < FILL_SPAN) return k;
    return MAP_DIM - 1 - (k - FILL_SPAN);
  endfunction

  function automatic bit wrap_neighbor(int c, int r, int dc, int dr,
                                       output int nc, output int nr);
    int ncols, nrows;
    bit off_map;
    ncols = used_extent(map_cfg.cols);
    nrows = used_extent(map_cfg.rows);
    nc = c + dc;
    nr = r + dr;
    off_map = 1'b0;
    if (nc < 0) begin
      off_map = 1'b1;
      nc = ncols - 1;
    end else if (nc >= ncols) begin
      off_map = 1'b1;
      nc = 0;
    end
    if (nr < 0) begin
      off_map = 1'b1;
      nr = nrows - 1;
    end else if (nr >= nrows) begin
      off_map = 1'b1;
      nr = 0;
    end
    return off_map;
  endfunction

  function automatic bit neighbor_set(int c, int r, int dc, int dr);
    int nc, nr;
    bit off_map;
    off_map = wrap_neighbor(c, r, dc, dr, nc, nr);
    if (off_map && map_cfg.mode != anc_pkg::EDGE_WRAP) return map_cfg.mode == anc_pkg::EDGE_ONE;
    return solid_map[nr][nc] | mask_map[nr][nc];
  endfunction

  function automatic bit neighbor_known(int c, int r, int dc, int dr);
    int nc, nr;
    bit off_map;
    off_map = wrap_neighbor(c, r, dc, dr, nc, nr);
    if (off_map && map_cfg.mode != anc_pkg::EDGE_WRAP) return 1'b1;
    return written_map[nr][nc];
  endfunction

  // classify only touches written cells
  function automatic bit cell_ready(int c, int r);
    if (c >= used_extent(map_cfg.cols) || r >= used_extent(map_cfg.rows)) return 1'b1;
    if (!written_map[r][c]) return 1'b0;
    if (!solid_map[r][c]) return 1'b1;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if ((dc != 0 || dr != 0) && !neighbor_known(c, r, dc, dr)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void pick_ready_cell(output int c, output int r);
    for (int tries = 0; tries < 64; tries++) begin
      if ($urandom_range(0, 1) == 0) begin
        c = fill_coord($urandom_range(0, FILL_COUNT - 1));
        r = fill_coord($urandom_range(0, FILL_COUNT - 1));
      end else begin
        c = $urandom_range(0, MAP_DIM - 1);
        r = $urandom_range(0, MAP_DIM - 1);
      end
      if (cell_ready(c, r)) return;
    end
    c = 1;
    r = 1;
  endfunction

  function automatic logic [anc_pkg::CAT_W-1:0] tile_category(logic [anc_pkg::NB_W-1:0] nb);
    logic lf, rt, up, dn, ul, ur, dl, dr;
    {dr, dl, ur, ul, dn, up, rt, lf} = nb;
    if (&nb) return anc_pkg::CAT_CENTER;
    if (!up && !dn) begin
      if (lf && rt) return anc_pkg::CAT_HORIZ_C;
      if (lf) return anc_pkg::CAT_HORIZ_R;
      return rt ? anc_pkg::CAT_HORIZ_L : anc_pkg::CAT_SINGLE;
    end
    if (!lf && !rt) begin
      if (up && dn) return anc_pkg::CAT_VERT_C;
      return dn ? anc_pkg::CAT_VERT_T : anc_pkg::CAT_VERT_B;
    end
    if (up && dn) begin
      if (lf && !rt) return anc_pkg::CAT_RIGHT;
      if (rt && !lf) return anc_pkg::CAT_LEFT;
      if (dl && !dr) return anc_pkg::CAT_INSIDE_TL;
      if (dr && !dl) return anc_pkg::CAT_INSIDE_TR;
      if (ul && !ur) return anc_pkg::CAT_INSIDE_BL;
      if (ur && !ul) return anc_pkg::CAT_INSIDE_BR;
      return anc_pkg::CAT_TOP;
    end
    if (lf && rt) return dn ? anc_pkg::CAT_TOP : anc_pkg::CAT_BOTTOM;
    if (up) return rt ? anc_pkg::CAT_CORNER_BL : anc_pkg::CAT_CORNER_BR;
    return rt ? anc_pkg::CAT_CORNER_TL : anc_pkg::CAT_CORNER_TR;
  endfunction

  function automatic tile_result_t classify_cell(int c, int r);
    tile_result_t res;
    res.category = anc_pkg::CAT_EMPTY;
    res.nbits = '0;
    if (c < used_extent(map_cfg.cols) && r < used_extent(map_cfg.rows) && solid_map[r][c]) begin
      res.nbits[0] = neighbor_set(c, r, -1, 0);
      res.nbits[1] = neighbor_set(c, r, 1, 0);
      res.nbits[2] = neighbor_set(c, r, 0, 1);
      res.nbits[3] = neighbor_set(c, r, 0, -1);
      res.nbits[4] = neighbor_set(c, r, -1, 1);
      res.nbits[5] = neighbor_set(c, r, 1, 1);
      res.nbits[6] = neighbor_set(c, r, -1, -1);
      res.nbits[7] = neighbor_set(c, r, 1, -1);
      res.category = tile_category(res.nbits);
    end
    return res;
  endfunction

  // result checker and receiver-side stall generator
  always @(posedge clk) begin
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_tiles.size() == 0) begin
        $error("unexpected transaction: category %0d neighbor_bits %02h",
               out_ch.category, out_ch.neighbor_bits);
        mismatch_count++;
      end else begin
        want_tile = pending_tiles.pop_front();
        if (out_ch.category !== want_tile.category) begin
          $error("category: expected %0d, actual %0d", want_tile.category, out_ch.category);
          mismatch_count++;
        end
        if (out_ch.neighbor_bits !== want_tile.nbits) begin
          $error("neighbor_bits: expected %02h, actual %02h",
                 want_tile.nbits, out_ch.neighbor_bits);
          mismatch_count++;
        end
      end
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left = hold_request - 1;
      hold_request = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_smooth = ($urandom_range(0, 3) == 0);
        rx_phase_left = $urandom_range(20, 200);
      end else begin
        rx_phase_left--;
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!rx_smooth && $urandom_range(0, 3) == 0) begin
        rx_stall_left = idle_length();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic kind, int col, int row, logic solid, logic mask);
    int gap;
    gap = sender_burst ? 0 : idle_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.col       <= col[anc_pkg::COL_W-1:0];
    in_ch.row       <= row[anc_pkg::ROW_W-1:0];
    in_ch.solid_bit <= solid;
    in_ch.mask_bit  <= mask;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (kind == anc_pkg::KIND_LOAD) begin
      solid_map[row][col] = solid;
      mask_map[row][col] = mask;
      written_map[row][col] = 1'b1;
    end else begin
      pending_tiles.push_back(classify_cell(col, row));
    end
  endtask

  task automatic drain_block();
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_tiles.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [anc_pkg::CFG_IDX_W-1:0] idx, cfg_word_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      anc_pkg::REG_MAP_COLUMNS: map_cfg.cols = data;
      anc_pkg::REG_MAP_ROWS:    map_cfg.rows = data;
      anc_pkg::REG_EDGE_MODE:   map_cfg.mode = data[anc_pkg::MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_map(cfg_word_t cols, cfg_word_t rows, cfg_word_t mode);
    drain_block();
    write_reg(anc_pkg::REG_MAP_COLUMNS, cols);
    write_reg(anc_pkg::REG_MAP_ROWS, rows);
    write_reg(anc_pkg::REG_EDGE_MODE, mode);
    cfg_ch.valid <= 1'b0;
  endtask

  // low-index and top-edge cells, enough for every edge and corner case
  task automatic test_map_fill();
    for (int kr = 0; kr < FILL_COUNT; kr++) begin
      for (int kc = 0; kc < FILL_COUNT; kc++) begin
        send_item(anc_pkg::KIND_LOAD, fill_coord(kc), fill_coord(kr),
                  $urandom_range(0, 99) < 55, $urandom_range(0, 3) == 0);
      end
    end
  endtask

  task automatic test_field_extremes();
    send_item(anc_pkg::KIND_LOAD, 0, 0, 1'b1, 1'b0);
    send_item(anc_pkg::KIND_LOAD, MAP_DIM - 1, MAP_DIM - 1, 1'b1, 1'b0);
    send_item(anc_pkg::KIND_LOAD, MAP_DIM - 1, 0, 1'b1, 1'b1);
    send_item(anc_pkg::KIND_LOAD, 0, MAP_DIM - 1, 1'b1, 1'b1);
    send_item(anc_pkg::KIND_LOAD, 5, 40, 1'b0, 1'b1);
    send_item(anc_pkg::KIND_CLASSIFY, 0, 0, 1'b0, 1'b0);
    send_item(anc_pkg::KIND_CLASSIFY, MAP_DIM - 1, MAP_DIM - 1, 1'b1, 1'b1);
    send_item(anc_pkg::KIND_CLASSIFY, MAP_DIM - 1, 0, 1'b0, 1'b1);
    send_item(anc_pkg::KIND_CLASSIFY, 0, MAP_DIM - 1, 1'b1, 1'b0);
    send_item(anc_pkg::KIND_CLASSIFY, 5, 40, 1'b0, 1'b0);
  endtask

  task automatic test_edge_modes();
    set_map(7'd64, 7'd64, cfg_word_t'(anc_pkg::EDGE_ONE));
    send_item(anc_pkg::KIND_CLASSIFY, 0, 0, 1'b0, 1'b0);
    send_item(anc_pkg::KIND_CLASSIFY, MAP_DIM - 1, MAP_DIM - 1, 1'b0, 1'b0);
    set_map(7'd64, 7'd64, cfg_word_t'(anc_pkg::EDGE_WRAP));
    send_item(anc_pkg::KIND_CLASSIFY, 0, 0, 1'b0, 1'b0);
    send_item(anc_pkg::KIND_CLASSIFY, MAP_DIM - 1, 0, 1'b0, 1'b0);
    set_map(7'd64, 7'd64, cfg_word_t'(EDGE_SPARE));
    send_item(anc_pkg::KIND_CLASSIFY, 0, MAP_DIM - 1, 1'b0, 1'b0);
  endtask

  task automatic test_size_limits();
    set_map(7'd0, 7'd0, cfg_word_t'(anc_pkg::EDGE_WRAP));
    send_item(anc_pkg::KIND_LOAD, 0, 0, 1'b1, 1'b0);
    send_item(anc_pkg::KIND_CLASSIFY, 0, 0, 1'b0, 1'b0);
    send_item(anc_pkg::KIND_CLASSIFY, 1, 0, 1'b0, 1'b0);
    set_map(7'd127, 7'd100, cfg_word_t'(anc_pkg::EDGE_ONE));
    send_item(anc_pkg::KIND_CLASSIFY, MAP_DIM - 1, MAP_DIM - 1, 1'b0, 1'b0);
    set_map(7'd4, 7'd3, 7'h7E);
    send_item(anc_pkg::KIND_LOAD, 10, 10, 1'b1, 1'b0);
    send_item(anc_pkg::KIND_CLASSIFY, 3, 2, 1'b0, 1'b0);
    send_item(anc_pkg::KIND_CLASSIFY, 4, 0, 1'b0, 1'b0);
    send_item(anc_pkg::KIND_CLASSIFY, 0, 3, 1'b0, 1'b0);
    set_map(7'd64, 7'd64, cfg_word_t'(anc_pkg::EDGE_ZERO));
    write_reg(REG_SPARE, 7'h7F);
    cfg_ch.valid <= 1'b0;
    send_item(anc_pkg::KIND_CLASSIFY, 10, 10, 1'b0, 1'b0);
  endtask

  task automatic test_backpressure();
    int c, r;
    set_map(7'd64, 7'd64, cfg_word_t'(anc_pkg::EDGE_WRAP));
    hold_request = 300;
    sender_burst = 1'b1;
    for (int i = 0; i < 40; i++) begin
      pick_ready_cell(c, r);
      send_item(anc_pkg::KIND_CLASSIFY, c, r, 1'b0, 1'b0);
    end
    sender_burst = 1'b0;
  endtask

  task automatic test_random_neighborhoods();
    int items_left, ncols, nrows, c, r, pick, density;
    logic [1:0] occ;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_map(7'd64, 7'd64, cfg_word_t'(anc_pkg::EDGE_ZERO));
        1: set_map(cfg_word_t'($urandom_range(1, 8)), cfg_word_t'($urandom_range(1, 8)),
                   cfg_word_t'(anc_pkg::EDGE_WRAP));
        2: set_map(7'd0, 7'd127, cfg_word_t'(anc_pkg::EDGE_ONE));
        3: set_map(cfg_word_t'($urandom_range(1, 64)), cfg_word_t'($urandom_range(65, 127)),
                   cfg_word_t'($urandom_range(0, 127)));
        4: set_map(7'd2, 7'd2, cfg_word_t'(anc_pkg::EDGE_WRAP));
        default: set_map(cfg_word_t'($urandom_range(0, 127)), cfg_word_t'($urandom_range(0, 127)),
                         cfg_word_t'($urandom_range(0, 127)));
      endcase
      ncols = used_extent(map_cfg.cols);
      nrows = used_extent(map_cfg.rows);
      items_left = PHASE_ITEMS;
      while (items_left > 0) begin
        sender_burst = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) < 8) begin
          pick = $urandom_range(0, 9);
          c = (pick < 2) ? 0 : (pick < 4) ? ncols - 1 : $urandom_range(0, ncols - 1);
          pick = $urandom_range(0, 9);
          r = (pick < 2) ? 0 : (pick < 4) ? nrows - 1 : $urandom_range(0, nrows - 1);
          case ($urandom_range(0, 2))
            0: density = 15;
            1: density = 50;
            default: density = 92;
          endcase
          send_item(anc_pkg::KIND_LOAD, c, r, $urandom_range(0, 9) != 0,
                    1'($urandom_range(0, 1)));
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if (dc != 0 || dr != 0) begin
                occ = ($urandom_range(0, 99) < density) ? 2'($urandom_range(1, 3)) : 2'b00;
                send_item(anc_pkg::KIND_LOAD, (c + dc + ncols) % ncols, (r + dr + nrows) % nrows,
                          occ[0], occ[1]);
              end
            end
          end
          send_item(anc_pkg::KIND_CLASSIFY, c, r, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          items_left -= 10;
          if ($urandom_range(0, 9) < 4 &&
              cell_ready((c + 1) % ncols, (r + nrows - 1) % nrows)) begin
            send_item(anc_pkg::KIND_CLASSIFY, (c + 1) % ncols, (r + nrows - 1) % nrows,
                      1'b0, 1'b0);
            items_left--;
          end
        end else if ($urandom_range(0, 1) == 0) begin
          send_item(anc_pkg::KIND_LOAD, $urandom_range(0, MAP_DIM - 1),
                    $urandom_range(0, MAP_DIM - 1), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          items_left--;
        end else begin
          pick_ready_cell(c, r);
          send_item(anc_pkg::KIND_CLASSIFY, c, r, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          items_left--;
        end
      end
      sender_burst = 1'b0;
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= anc_pkg::KIND_LOAD;
    in_ch.col       <= '0;
    in_ch.row       <= '0;
    in_ch.solid_bit <= 1'b0;
    in_ch.mask_bit  <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= anc_pkg::REG_MAP_COLUMNS;
    cfg_ch.data     <= '0;
    map_cfg.cols = anc_pkg::SIZE_RESET;
    map_cfg.rows = anc_pkg::SIZE_RESET;
    map_cfg.mode = anc_pkg::EDGE_ZERO;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_map_fill();
    test_field_extremes();
    test_edge_modes();
    test_size_limits();
    test_backpressure();
    test_random_neighborhoods();
    drain_block();

    if (pending_tiles.size() != 0) begin
      $error("%0d expected transactions never arrived", pending_tiles.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
